// ===== rtl/rtch_pkg.sv =====
// rtch_pkg: shared types and constants for the ray/triangle closest-hit block.
// No dependencies; imported by the front, back and top level.
package rtch_pkg;

  // Quotient bits produced by the back-end divider and fraction bits of results
  localparam int DIV_STEPS = 34;
  localparam int FRAC_BITS = 16;

  // Per-triangle sideband carried alongside the arithmetic
  typedef struct packed {
    logic               first;
    logic               last;
    logic signed [31:0] near_lim;
    logic signed [31:0] far_lim;
    logic [15:0]        index;
  } side_t;

endpackage

// ===== rtl/rtch_front.sv =====
// rtch_front: five-stage pipelined Moller-Trumbore front end (edges, crosses,
// dots, sign normalise, classify). Depends on rtch_pkg.
module rtch_front
  import rtch_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int DW         = 3 * COORD_BITS + 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [19:0]   det_epsilon,
  input  side_t         in_side,
  input  logic [62:0]   ray_origin,
  input  logic [62:0]   ray_direction,
  input  logic [62:0]   corner_a,
  input  logic [62:0]   corner_b,
  input  logic [62:0]   corner_c,
  output logic          cls_valid,
  input  logic          cls_ready,
  output side_t         cls_side,
  output logic [DW-1:0] cls_det,
  output logic [DW-1:0] cls_un,
  output logic [DW-1:0] cls_vn,
  output logic [DW-1:0] cls_tmag,
  output logic          cls_tneg,
  output logic          cls_cand
);

  localparam int C = COORD_BITS;
  localparam int E = C + 1;
  localparam int X = 2 * C + 3;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || cls_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign full = !rdy1;
  assign cls_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= push;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: unpack, edges
  logic signed [C-1:0] org [3], dir [3], ca [3], cb [3], cc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org[k] = ray_origin[k*C +: C];
      dir[k] = ray_direction[k*C +: C];
      ca[k]  = corner_a[k*C +: C];
      cb[k]  = corner_b[k*C +: C];
      cc[k]  = corner_c[k*C +: C];
    end
  end

  side_t s1_side, s2_side, s3_side, s4_side;
  logic signed [C-1:0] s1_dir [3], s2_dir [3];
  logic signed [E-1:0] s1_e1 [3], s1_e2 [3], s1_tv [3];
  logic signed [E-1:0] s2_e1 [3], s2_e2 [3], s2_tv [3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_side <= in_side;
      for (int k = 0; k < 3; k++) begin
        s1_dir[k] <= dir[k];
        s1_e1[k]  <= E'(cb[k]) - E'(ca[k]);
        s1_e2[k]  <= E'(cc[k]) - E'(ca[k]);
        s1_tv[k]  <= E'(org[k]) - E'(ca[k]);
      end
    end
  end

  // stage 2: pvec = dir x e2, qvec = tvec x e1
  logic signed [X-1:0] pa [3], pb [3], qa [3], qb [3];
  logic signed [X-1:0] s2_pv [3], s2_qv [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = s1_dir[(k+1)%3] * s1_e2[(k+2)%3];
      pb[k] = s1_dir[(k+2)%3] * s1_e2[(k+1)%3];
      qa[k] = s1_tv[(k+1)%3] * s1_e1[(k+2)%3];
      qb[k] = s1_tv[(k+2)%3] * s1_e1[(k+1)%3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_side <= s1_side;
      for (int k = 0; k < 3; k++) begin
        s2_pv[k]  <= pa[k] - pb[k];
        s2_qv[k]  <= qa[k] - qb[k];
        s2_dir[k] <= s1_dir[k];
        s2_e1[k]  <= s1_e1[k];
        s2_e2[k]  <= s1_e2[k];
        s2_tv[k]  <= s1_tv[k];
      end
    end
  end

  // stage 3: det, u/v/t numerators
  logic signed [DW-1:0] m_det [3], m_un [3], m_vn [3], m_tn [3];
  logic signed [DW-1:0] s3_det, s3_un, s3_vn, s3_tn;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_det[k] = s2_e1[k] * s2_pv[k];
      m_un[k]  = s2_tv[k] * s2_pv[k];
      m_vn[k]  = s2_dir[k] * s2_qv[k];
      m_tn[k]  = s2_e2[k] * s2_qv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_side <= s2_side;
      s3_det  <= m_det[0] + m_det[1] + m_det[2];
      s3_un   <= m_un[0] + m_un[1] + m_un[2];
      s3_vn   <= m_vn[0] + m_vn[1] + m_vn[2];
      s3_tn   <= m_tn[0] + m_tn[1] + m_tn[2];
    end
  end

  // stage 4: fold det sign into the numerators; t kept as magnitude and sign
  logic signed [DW-1:0] s4_det, s4_un, s4_vn, s4_tmag;
  logic                 s4_tneg;
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_side <= s3_side;
      s4_det  <= s3_det[DW-1] ? -s3_det : s3_det;
      s4_un   <= s3_det[DW-1] ? -s3_un : s3_un;
      s4_vn   <= s3_det[DW-1] ? -s3_vn : s3_vn;
      s4_tmag <= s3_tn[DW-1] ? -s3_tn : s3_tn;
      s4_tneg <= s3_tn[DW-1] ^ s3_det[DW-1];
    end
  end

  // stage 5: classify; also drop t quotients too large for the divider
  logic signed [DW-1:0] eps_ext;
  logic signed [DW:0]   uv_sum;
  logic                 cand;
  assign eps_ext = DW'({1'b0, det_epsilon});
  assign uv_sum  = (DW+1)'(s4_un) + (DW+1)'(s4_vn);
  assign cand = (s4_det != '0) && (s4_det >= eps_ext) && !s4_un[DW-1] && (s4_un <= s4_det)
             && !s4_vn[DW-1] && (uv_sum <= (DW+1)'(s4_det))
             && ((s4_tmag >>> (DIV_STEPS - FRAC_BITS)) < s4_det);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      cls_side <= s4_side;
      cls_det  <= s4_det;
      cls_un   <= s4_un;
      cls_vn   <= s4_vn;
      cls_tmag <= s4_tmag;
      cls_tneg <= s4_tneg;
      cls_cand <= cand;
    end
  end

endmodule

// ===== rtl/rtch_queue.sv =====
// rtch_queue: small register FIFO between front and back end.
// No dependencies.
module rtch_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      count;
  logic             do_wr, do_rd;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/rtch_back.sv =====
// rtch_back: restoring divider for t, u, v, closest-hit keeping and result register.
// Depends on rtch_pkg.
module rtch_back
  import rtch_pkg::*;
#(
  parameter int DW         = 69,
  parameter int INDEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  side_t              q_side,
  input  logic [DW-1:0]      q_det,
  input  logic [DW-1:0]      q_un,
  input  logic [DW-1:0]      q_vn,
  input  logic [DW-1:0]      q_tmag,
  input  logic               q_tneg,
  input  logic               q_cand,
  output logic               empty,
  input  logic               pop,
  output logic               hit_found,
  output logic signed [31:0] hit_distance,
  output logic [16:0]        bary_u,
  output logic [16:0]        bary_v,
  output logic [15:0]        hit_index
);

  localparam int CW = $clog2(DIV_STEPS);
  localparam int TW = DIV_STEPS + 2;
  localparam int SH = DIV_STEPS - FRAC_BITS;
  localparam logic [15:0] IDX_MASK =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_BITS) - 32'd1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } back_state_t;

  back_state_t state;
  side_t       cur;
  logic [DW-1:0]        det;
  logic                 cand, tneg;
  logic [CW-1:0]        cnt;
  // lane 0: t, lane 1: u, lane 2: v
  logic [DW-1:0]        rem [3];
  logic [DIV_STEPS-1:0] dvd [3], quo [3];
  logic [DW:0]          trial [3];
  logic                 take [3];

  logic signed [31:0]   bound, best_dist;
  logic [16:0]          best_u, best_v;
  logic [15:0]          best_index;
  logic                 any_hit, out_valid;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem[k], dvd[k][DIV_STEPS-1]};
      take[k]  = trial[k] >= {1'b0, det};
    end
  end

  // t = -(q + (rem != 0)) when negative, floor rounding
  logic signed [TW-1:0] tq_pos, tq;
  logic                 hit, fin_go;
  assign tq_pos = TW'(quo[0]) + TW'(rem[0] != '0);
  assign tq     = tneg ? -tq_pos : TW'(quo[0]);
  assign hit    = cand && (tq >= TW'(cur.near_lim)) && (tq <= TW'(bound));
  assign fin_go = (state == ST_FIN) && (!cur.last || !out_valid || pop);
  assign q_pop  = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      bound <= '0;
      best_dist <= '0;
      best_u <= '0;
      best_v <= '0;
      best_index <= '0;
      any_hit <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur  <= q_side;
            det  <= q_det;
            cand <= q_cand;
            tneg <= q_tneg;
            cnt  <= '0;
            rem[0] <= q_tmag >> SH;
            rem[1] <= q_un >> SH;
            rem[2] <= q_vn >> SH;
            dvd[0] <= DIV_STEPS'({q_tmag, {FRAC_BITS{1'b0}}});
            dvd[1] <= DIV_STEPS'({q_un, {FRAC_BITS{1'b0}}});
            dvd[2] <= DIV_STEPS'({q_vn, {FRAC_BITS{1'b0}}});
            for (int k = 0; k < 3; k++) quo[k] <= '0;
            if (q_side.first) begin
              bound <= q_side.far_lim;
              best_dist <= '0;
              best_u <= '0;
              best_v <= '0;
              best_index <= '0;
              any_hit <= 1'b0;
            end
            state <= q_cand ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= take[k] ? DW'(trial[k] - {1'b0, det}) : DW'(trial[k]);
            dvd[k] <= dvd[k] << 1;
            quo[k] <= {quo[k][DIV_STEPS-2:0], take[k]};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DIV_STEPS - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            if (hit) begin
              bound <= tq[31:0];
              best_dist <= tq[31:0];
              best_u <= quo[1][16:0];
              best_v <= quo[2][16:0];
              best_index <= cur.index & IDX_MASK;
              any_hit <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register; a new result may load in the cycle the old one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go && cur.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && cur.last) begin
      hit_found    <= hit || any_hit;
      hit_distance <= hit ? tq[31:0] : best_dist;
      bary_u       <= hit ? quo[1][16:0] : best_u;
      bary_v       <= hit ? quo[2][16:0] : best_v;
      hit_index    <= hit ? (cur.index & IDX_MASK) : best_index;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/ray_triangle_closest_hit_top.sv =====
// ray_triangle_closest_hit_top: top level of the closest-hit ray/triangle block.
// Depends on rtch_pkg, rtch_front, rtch_queue and rtch_back.
//
// Feeds a stream of triangles tested against one ray and returns the closest
// hit when the beat marked last_of_ray has been tested. first_of_ray clears the
// kept hit and loads the far bound from far_limit; without it the search goes
// on from the previous beat. Arithmetic is exact integer Moller-Trumbore on
// signed Q10.10 corners; |det| below det_epsilon (units of 2^-30) or a zero det
// rejects, as do u, v outside the triangle and distances outside near..bound.
// A hit at a distance equal to the bound replaces the kept one. Distances are
// floor-rounded Q16.16, u and v floor-rounded Q1.16. The front end is a five
// stage pipeline that takes one triangle per cycle, unless full, into a
// two-beat queue; the back end pops one triangle at a time. A rejected
// triangle goes from pop to finish, a candidate through pop, 34 steps of a
// shared three-lane restoring divider for t, u and v, and finish, so that
// divider sets the sustained throughput. A last beat waits in the back end
// only while the one-entry result register is still occupied. The user must
// write det_epsilon through the cfg port (always ready) only while the block
// is idle; the block itself does not enforce this. Its reset value is 1024.
module ray_triangle_closest_hit_top
  import rtch_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int INDEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               first_of_ray,
  input  logic               last_of_ray,
  input  logic [62:0]        ray_origin,
  input  logic [62:0]        ray_direction,
  input  logic signed [31:0] near_limit,
  input  logic signed [31:0] far_limit,
  input  logic [62:0]        corner_a,
  input  logic [62:0]        corner_b,
  input  logic [62:0]        corner_c,
  input  logic [15:0]        triangle_index,
  output logic               empty,
  input  logic               pop,
  output logic               hit_found,
  output logic signed [31:0] hit_distance,
  output logic [16:0]        bary_u,
  output logic [16:0]        bary_v,
  output logic [15:0]        hit_index
);

  // numerator width: edge (C+1) by cross term (2C+3), summed over three axes
  localparam int DW = 3 * COORD_BITS + 6;
  localparam int QW = $bits(side_t) + 4 * DW + 2;

  logic [19:0] det_epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) det_epsilon <= 20'd1024;
    else if (cfg_valid) det_epsilon <= cfg_data;
  end

  side_t in_side;
  always_comb begin
    in_side.first    = first_of_ray;
    in_side.last     = last_of_ray;
    in_side.near_lim = near_limit;
    in_side.far_lim  = far_limit;
    in_side.index    = triangle_index;
  end

  logic          cls_valid, cls_ready, cls_tneg, cls_cand;
  side_t         cls_side;
  logic [DW-1:0] cls_det, cls_un, cls_vn, cls_tmag;

  rtch_front #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .det_epsilon   (det_epsilon),
    .in_side       (in_side),
    .ray_origin    (ray_origin),
    .ray_direction (ray_direction),
    .corner_a      (corner_a),
    .corner_b      (corner_b),
    .corner_c      (corner_c),
    .cls_valid     (cls_valid),
    .cls_ready     (cls_ready),
    .cls_side      (cls_side),
    .cls_det       (cls_det),
    .cls_un        (cls_un),
    .cls_vn        (cls_vn),
    .cls_tmag      (cls_tmag),
    .cls_tneg      (cls_tneg),
    .cls_cand      (cls_cand)
  );

  logic          q_valid, q_pop, q_tneg, q_cand;
  logic [QW-1:0] q_data;
  side_t         q_side;
  logic [DW-1:0] q_det, q_un, q_vn, q_tmag;

  rtch_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  ({cls_side, cls_det, cls_un, cls_vn, cls_tmag, cls_tneg, cls_cand}),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  assign {q_side, q_det, q_un, q_vn, q_tmag, q_tneg, q_cand} = q_data;

  rtch_back #(
    .DW         (DW),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_side       (q_side),
    .q_det        (q_det),
    .q_un         (q_un),
    .q_vn         (q_vn),
    .q_tmag       (q_tmag),
    .q_tneg       (q_tneg),
    .q_cand       (q_cand),
    .empty        (empty),
    .pop          (pop),
    .hit_found    (hit_found),
    .hit_distance (hit_distance),
    .bary_u       (bary_u),
    .bary_v       (bary_v),
    .hit_index    (hit_index)
  );

endmodule

// ===== rtl/rtch_checker.sv =====
// rtch_checker: port-level assertions for the closest-hit block, bound to the top.
// Depends only on the top level's ports.
module rtch_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic               hit_found,
  input logic signed [31:0] hit_distance,
  input logic [16:0]        bary_u,
  input logic [16:0]        bary_v,
  input logic [15:0]        hit_index
);

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible after reset");

  // a waiting result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hit_distance) && $stable(hit_index)
                          && $stable(bary_u) && $stable(bary_v) && $stable(hit_found)))
    else $error("result changed while stalled");

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit_found) |-> (hit_distance == 32'sd0 && bary_u == 17'd0
                                && bary_v == 17'd0 && hit_index == 16'd0))
    else $error("miss with non-zero fields");

  // barycentrics of a hit stay inside the triangle
  a_bary_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (({1'b0, bary_u} + {1'b0, bary_v}) <= 18'd65536))
    else $error("u + v above one");

endmodule

bind ray_triangle_closest_hit_top rtch_checker u_rtch_checker (.*);
